FILE: rtl/indexed_list_insert_delete_top_assert.svh
// Assertion macros for the indexed list block.
// Used by the top level; no other dependencies.
`ifndef INDEXED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ILID_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ILID_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`define ILID_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");
`else
`define ILID_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define ILID_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`define ILID_ASSERT_ALWAYS(name, clk, rst_n, expr)
`endif
`endif

FILE: rtl/ilid_pkg.sv
// Shared types and constants for the indexed list block.
// No dependencies; imported by the cell and the top level.
package ilid_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int MAG_W    = POS_W - 1;
    localparam int CMP_W    = (CNT_W > MAG_W) ? CNT_W : MAG_W;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 7;

    typedef enum logic [2:0] {
        FUNC_READ   = 3'd0,
        FUNC_HEAD   = 3'd1,
        FUNC_TAIL   = 3'd2,
        FUNC_AT     = 3'd3,
        FUNC_DELETE = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [IDX_W-1:0]   k;
        logic [DATA_W-1:0]  value;
    } t_cell_ctl;

endpackage

FILE: rtl/ilid_cell.sv
// One storage cell of the list row: holds a single entry.
// Depends on ilid_pkg for the control struct and widths.
module ilid_cell
    import ilid_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_value,
    output logic [DATA_W-1:0] o_sel_value
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // Insert shifts the tail right by one, delete pulls it left by one.
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_index > i_ctl.k) begin
                n_value = i_left;
            end else if (i_index == i_ctl.k) begin
                n_value = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (i_index >= i_ctl.k) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // The addressed cell puts its entry on the shared read bus.
    assign o_value     = r_value;
    assign o_sel_value = (i_index == i_ctl.k) ? r_value : '0;

endmodule

FILE: rtl/indexed_list_insert_delete_top.sv
// Channel  | Dir | Handshake          | Payload
// command  | in  | i_valid / o_ready  | i_func, i_position, i_item_value
// result   | out | o_valid / i_ready  | o_read_value, o_status, o_length
//
// Each command is executed in the cycle it is accepted; the whole row of cells
// shifts at once, and the result appears in the output register in the next cycle.
// Sustained rate is one command per cycle, limited only by the output register.
// Reset (synchronous, active low) empties the list and clears the result valid.
// A stalled result holds, and a new command is taken only when the output
// register is empty or being drained in the same cycle.
// Depends on ilid_pkg, ilid_cell and the assertion macro header.
`include "indexed_list_insert_delete_top_assert.svh"
module indexed_list_insert_delete_top
    import ilid_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_func,
    input  logic signed [POS_W-1:0]  i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [1:0]               o_status,
    output logic [LEN_W-1:0]         o_length
);

    logic              r_out_valid;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [DATA_W-1:0] r_read_value;
    logic [DATA_W-1:0] n_read_value;
    t_status           r_status;
    t_status           n_status;

    logic              in_acc;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [CMP_W-1:0]  mag_cmp;
    logic [CMP_W-1:0]  cnt_cmp;
    logic [CMP_W-1:0]  at_cmp;
    logic              pos_ok;
    logic              full;
    logic              is_ins;
    logic              is_del;
    logic [IDX_W-1:0]  row_k;
    t_cell_ctl         ctl;
    logic [DATA_W-1:0] bus_value;

    logic [DATA_W-1:0] cell_value [CAPACITY];
    logic [DATA_W-1:0] cell_sel   [CAPACITY];

    assign in_acc  = i_valid && o_ready;
    assign o_ready = !r_out_valid || i_ready;

    // Position decode against the current length.
    assign neg     = i_position[POS_W-1];
    assign mag     = i_position[MAG_W-1:0];
    assign mag_cmp = CMP_W'(mag);
    assign cnt_cmp = CMP_W'(r_count);
    assign at_cmp  = neg ? '0 : mag_cmp;
    assign pos_ok  = !neg && (mag_cmp < cnt_cmp);
    assign full    = r_count >= CNT_W'(CAPACITY);

    // Command decode: choose the row operation, the status and the new length.
    always_comb begin
        is_ins       = 1'b0;
        is_del       = 1'b0;
        row_k        = IDX_W'(mag);
        n_status     = ST_DONE;
        n_read_value = '0;
        n_count      = r_count;
        case (t_func'(i_func))
            FUNC_READ: begin
                if (pos_ok) begin
                    n_read_value = bus_value;
                end else begin
                    n_read_value = '1;
                    n_status     = ST_BAD_POS;
                end
            end
            FUNC_HEAD: begin
                row_k = '0;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    is_ins = 1'b1;
                end
            end
            FUNC_TAIL: begin
                row_k = IDX_W'(r_count);
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    is_ins = 1'b1;
                end
            end
            FUNC_AT: begin
                row_k = IDX_W'(at_cmp);
                if (at_cmp > cnt_cmp) begin
                    n_status = ST_BAD_POS;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    is_ins = 1'b1;
                end
            end
            FUNC_DELETE: begin
                if (pos_ok) begin
                    is_del = 1'b1;
                end else begin
                    n_status = ST_BAD_POS;
                end
            end
            default: begin
                n_status = ST_BAD_POS;
            end
        endcase
        if (is_ins) begin
            n_count = r_count + 1'b1;
        end else if (is_del) begin
            n_count = r_count - 1'b1;
        end
    end

    // Row control, broadcast to every cell.
    assign ctl = '{ins: in_acc && is_ins, del: in_acc && is_del, k: row_k,
                   value: i_item_value};

    // The row of cells, each linked to its left and right neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;
        if (g == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_mid_l
            assign left_value = cell_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_mid_r
            assign right_value = cell_value[g+1];
        end
        ilid_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_index     (IDX_W'(g)),
            .i_left      (left_value),
            .i_right     (right_value),
            .o_value     (cell_value[g]),
            .o_sel_value (cell_sel[g])
        );
    end

    // Only the addressed cell drives a nonzero value, so OR the row together.
    always_comb begin
        bus_value = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            bus_value = bus_value | cell_sel[j];
        end
    end

    // Length register and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_length     = LEN_W'(r_count);

    `ILID_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `ILID_ASSERT_IMPL(a_full_only_at_cap, i_clk, i_rst_n, in_acc && n_status == ST_FULL, full)
    `ILID_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, ctl.ins, r_count == $past(r_count) + 1'b1)
    `ILID_ASSERT_NEXT(a_del_shrinks, i_clk, i_rst_n, ctl.del, r_count == $past(r_count) - 1'b1)
    `ILID_ASSERT_IMPL(a_one_row_op, i_clk, i_rst_n, 1'b1, !(ctl.ins && ctl.del))

endmodule
